@@ hdl/smrs_pkg.sv @@
// Shared types, constants and default map contents for the segment map read splitter.
package smrs_pkg;

   localparam int WORD_W        = 32;
   localparam int RESULT_LIMIT  = 4;
   localparam int COUNT_W       = $clog2(RESULT_LIMIT + 1);
   localparam int SLOT_W        = $clog2(RESULT_LIMIT);
   localparam int ACTIVE_W      = 3;
   localparam int DEFAULT_LINES = 4;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd3;

   localparam logic OP_MAP_WRITE = 1'b0;
   localparam logic OP_READ      = 1'b1;

   localparam logic [1:0] WORD_ROM_START = 2'd0;
   localparam logic [1:0] WORD_RAM_START = 2'd1;
   localparam logic [1:0] WORD_RAM_END   = 2'd2;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type DEFAULT_ROM [DEFAULT_LINES] =
      '{32'h00008000, 32'h00406000, 32'h00C06000, 32'h01C06000};
   localparam word_type DEFAULT_RAM_START [DEFAULT_LINES] =
      '{32'h0C3E2000, 32'h0C800000, 32'h03700000, 32'h03700000};
   localparam word_type DEFAULT_RAM_END [DEFAULT_LINES] =
      '{32'h0C7E0000, 32'h0D000000, 32'h03778000, 32'h03778000};

   typedef struct packed {
      word_type rom_start;
      word_type delta;
      word_type ram_end;
   } line_type;

   typedef struct packed {
      logic in_use;
      logic is_last;
   } line_ctl_type;

   typedef struct packed {
      word_type src;
      word_type dst;
      word_type len;
   } piece_type;

   typedef struct packed {
      word_type                         src;
      word_type                         dst;
      word_type                         rem;
      logic [COUNT_W-1:0]               count;
      logic                             done;
      piece_type [RESULT_LIMIT-1:0]     pieces;
   } flow_type;

   function automatic word_type default_word(int line, logic [1:0] sel);
      word_type w;
      w = '0;
      if (line < DEFAULT_LINES) begin
         case (sel)
            WORD_ROM_START: w = DEFAULT_ROM[line[1:0]];
            WORD_RAM_START: w = DEFAULT_RAM_START[line[1:0]];
            WORD_RAM_END:   w = DEFAULT_RAM_END[line[1:0]];
            default:        w = '0;
         endcase
      end
      return w;
   endfunction

endpackage

@@ hdl/smrs_req_if.sv @@
// Request channel: map writes and read requests.
interface smrs_req_if;
   import smrs_pkg::*;
   logic       valid;
   logic       ready;
   logic       op;
   logic [1:0] line_index;
   logic [1:0] word_select;
   word_type   word_value;
   word_type   rom_offset;
   word_type   dest_address;
   word_type   byte_count;

   modport source (output valid, op, line_index, word_select, word_value,
                   rom_offset, dest_address, byte_count, input ready);
   modport sink   (input valid, op, line_index, word_select, word_value,
                   rom_offset, dest_address, byte_count, output ready);
endinterface

@@ hdl/smrs_rsp_if.sv @@
// Response channel: one piece of a split read per transfer.
interface smrs_rsp_if;
   import smrs_pkg::*;
   logic     valid;
   logic     ready;
   word_type ram_source;
   word_type piece_dest;
   word_type piece_length;
   logic     no_match;
   logic     truncated;
   logic     last_piece;

   modport source (output valid, ram_source, piece_dest, piece_length, no_match,
                   truncated, last_piece, input ready);
   modport sink   (input valid, ram_source, piece_dest, piece_length, no_match,
                   truncated, last_piece, output ready);
endinterface

@@ hdl/smrs_csr_if.sv @@
// Configuration write channel for the active line count.
interface smrs_csr_if;
   import smrs_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTIVE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ hdl/segment_map_read_splitter.sv @@
// Top level of the segment map read splitter.
// A read request flows through three register stages per map line (match, end test,
// cut); the line pipeline takes a new request every cycle while the response
// register does not stall it, and the response register hands out one piece per cycle
// while the receiver is ready, so a request that yields k pieces (1 to 4) holds the
// output until all k pieces are taken. Map writes (op 0) update the table directly
// and are held off while any read request is still in the line pipeline. The map
// resets to its default contents at once; there is no clearing pass.
module segment_map_read_splitter #(
   parameter int MAX_LINES = 4
) (
   input  logic       clock,
   input  logic       reset,
   smrs_req_if.sink   req_ch,
   smrs_rsp_if.source rsp_ch,
   smrs_csr_if.sink   csr_ch
);
   import smrs_pkg::*;

   localparam int LINE_CNT_W = $clog2(MAX_LINES + 1);

   logic [ACTIVE_W-1:0]   active_ff;
   logic [LINE_CNT_W-1:0] n_lines;
   line_type              lines    [MAX_LINES];
   line_ctl_type          ctl      [MAX_LINES];
   word_type              rom_next [MAX_LINES];
   flow_type              flow     [MAX_LINES+1];
   logic [MAX_LINES:0]    vld;
   logic [MAX_LINES-1:0]  stage_busy;
   logic                  busy, en, ser_load_ok, map_wr;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         active_ff <= csr_ch.data;
      end
   end

   always_comb begin
      if (active_ff == '0) begin
         n_lines = LINE_CNT_W'(1);
      end else if (int'(active_ff) > MAX_LINES) begin
         n_lines = LINE_CNT_W'(MAX_LINES);
      end else begin
         n_lines = LINE_CNT_W'(active_ff);
      end
      for (int i = 0; i < MAX_LINES; i++) begin
         ctl[i].in_use  = (LINE_CNT_W'(i) < n_lines);
         ctl[i].is_last = (LINE_CNT_W'(i + 1) == n_lines);
      end
   end

   assign busy   = |stage_busy;
   assign en     = !vld[MAX_LINES] || ser_load_ok;
   assign req_ch.ready = (req_ch.op == OP_READ) ? en : !busy;
   assign map_wr = req_ch.valid && req_ch.ready && (req_ch.op == OP_MAP_WRITE);

   always_comb begin
      flow[0].src    = req_ch.rom_offset;
      flow[0].dst    = req_ch.dest_address;
      flow[0].rem    = req_ch.byte_count;
      flow[0].count  = '0;
      flow[0].done   = 1'b0;
      flow[0].pieces = '0;
   end
   assign vld[0] = req_ch.valid && (req_ch.op == OP_READ);

   smrs_map #(.MAX_LINES(MAX_LINES)) u_map (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (map_wr),
      .line_index  (req_ch.line_index),
      .word_select (req_ch.word_select),
      .word_value  (req_ch.word_value),
      .lines       (lines)
   );

   for (genvar i = 0; i < MAX_LINES; i++) begin : g_line
      if (i < MAX_LINES - 1) begin : g_next
         assign rom_next[i] = lines[i+1].rom_start;
      end else begin : g_end
         assign rom_next[i] = '0;
      end

      smrs_line_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vld[i]),
         .in_flow   (flow[i]),
         .line_cfg  (lines[i]),
         .rom_next  (rom_next[i]),
         .ctl       (ctl[i]),
         .out_valid (vld[i+1]),
         .out_flow  (flow[i+1]),
         .busy      (stage_busy[i])
      );
   end

   smrs_serializer u_ser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (vld[MAX_LINES]),
      .in_flow  (flow[MAX_LINES]),
      .load_ok  (ser_load_ok),
      .rsp      (rsp_ch)
   );

   a_map_write_idle: assert property (@(posedge clock) disable iff (reset)
      map_wr |-> !busy)
      else $error("map write taken with a read request in flight");

   a_tail_held: assert property (@(posedge clock) disable iff (reset)
      (vld[MAX_LINES] && !ser_load_ok) |=> vld[MAX_LINES])
      else $error("stalled request dropped at pipeline tail");

endmodule

@@ hdl/smrs_map.sv @@
// Map line storage with precomputed RAM minus ROM start per line.
module smrs_map #(
   parameter int MAX_LINES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [1:0]          line_index,
   input  logic [1:0]          word_select,
   input  smrs_pkg::word_type  word_value,
   output smrs_pkg::line_type  lines [MAX_LINES]
);
   import smrs_pkg::*;

   word_type rom_ff       [MAX_LINES];
   word_type ram_start_ff [MAX_LINES];
   word_type ram_end_ff   [MAX_LINES];
   word_type delta_ff     [MAX_LINES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_LINES; i++) begin
            rom_ff[i]       <= default_word(i, WORD_ROM_START);
            ram_start_ff[i] <= default_word(i, WORD_RAM_START);
            ram_end_ff[i]   <= default_word(i, WORD_RAM_END);
            delta_ff[i]     <= default_word(i, WORD_RAM_START) -
                               default_word(i, WORD_ROM_START);
         end
      end else if (wr_en) begin
         for (int i = 0; i < MAX_LINES; i++) begin
            if (int'(line_index) == i) begin
               case (word_select)
                  WORD_ROM_START: begin
                     rom_ff[i]   <= word_value;
                     delta_ff[i] <= ram_start_ff[i] - word_value;
                  end
                  WORD_RAM_START: begin
                     ram_start_ff[i] <= word_value;
                     delta_ff[i]     <= word_value - rom_ff[i];
                  end
                  WORD_RAM_END: ram_end_ff[i] <= word_value;
                  default: ;
               endcase
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_LINES; i++) begin
         lines[i].rom_start = rom_ff[i];
         lines[i].delta     = delta_ff[i];
         lines[i].ram_end   = ram_end_ff[i];
      end
   end

endmodule

@@ hdl/smrs_line_stage.sv @@
// Three register stages that test one map line and cut at most one piece from the request.
module smrs_line_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  smrs_pkg::flow_type    in_flow,
   input  smrs_pkg::line_type    line_cfg,
   input  smrs_pkg::word_type    rom_next,
   input  smrs_pkg::line_ctl_type ctl,
   output logic                  out_valid,
   output smrs_pkg::flow_type    out_flow,
   output logic                  busy
);
   import smrs_pkg::*;

   logic     a_valid_ff, b_valid_ff, c_valid_ff;
   flow_type a_flow_ff, b_flow_ff, c_flow_ff;
   flow_type c_flow_in;
   logic     a_holds_ff, a_holds_in, b_holds_ff;
   word_type a_ram_src_ff, a_ram_src_in, b_ram_src_ff;
   logic     b_split_ff, b_split_in;
   word_type b_piece_ff, b_piece_in;

   // stage A: line match and RAM source
   always_comb begin
      a_holds_in = !in_flow.done && (in_flow.count != COUNT_W'(RESULT_LIMIT)) &&
                   ctl.in_use && (in_flow.src >= line_cfg.rom_start) &&
                   (ctl.is_last || (in_flow.src < rom_next));
      a_ram_src_in = line_cfg.delta + in_flow.src;
   end

   // stage B: RAM end test on the exact sum, room left in the line
   always_comb begin
      b_split_in = ({1'b0, a_ram_src_ff} + {1'b0, a_flow_ff.rem}) >
                   {1'b0, line_cfg.ram_end};
      b_piece_in = (line_cfg.ram_end > a_ram_src_ff) ?
                   (line_cfg.ram_end - a_ram_src_ff) : '0;
   end

   // stage C: emit the piece and advance
   always_comb begin
      c_flow_in = b_flow_ff;
      if (b_holds_ff) begin
         c_flow_in.pieces[b_flow_ff.count[SLOT_W-1:0]].src = b_ram_src_ff;
         c_flow_in.pieces[b_flow_ff.count[SLOT_W-1:0]].dst = b_flow_ff.dst;
         c_flow_in.pieces[b_flow_ff.count[SLOT_W-1:0]].len =
            b_split_ff ? b_piece_ff : b_flow_ff.rem;
         c_flow_in.count = b_flow_ff.count + COUNT_W'(1);
         if (b_split_ff) begin
            c_flow_in.src = b_flow_ff.src + b_piece_ff;
            c_flow_in.dst = b_flow_ff.dst + b_piece_ff;
            c_flow_in.rem = b_flow_ff.rem - b_piece_ff;
         end else begin
            c_flow_in.done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_flow_ff    <= in_flow;
         a_holds_ff   <= a_holds_in;
         a_ram_src_ff <= a_ram_src_in;
         b_flow_ff    <= a_flow_ff;
         b_holds_ff   <= a_holds_ff;
         b_ram_src_ff <= a_ram_src_ff;
         b_split_ff   <= b_split_in;
         b_piece_ff   <= b_piece_in;
         c_flow_ff    <= c_flow_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_flow  = c_flow_ff;
   assign busy      = a_valid_ff | b_valid_ff | c_valid_ff;

endmodule

@@ hdl/smrs_serializer.sv @@
// Response register that hands out the pieces of one request, one per cycle while rsp.ready is high.
module smrs_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  smrs_pkg::flow_type in_flow,
   output logic               load_ok,
   smrs_rsp_if.source         rsp
);
   import smrs_pkg::*;

   logic                         valid_ff, valid_in;
   logic [SLOT_W-1:0]            idx_ff, idx_in;
   logic [COUNT_W-1:0]           num_ff;
   logic                         nm_ff, tr_ff;
   piece_type [RESULT_LIMIT-1:0] slots_ff;
   logic                         is_last, take, finish, load;

   always_comb begin
      is_last  = ({1'b0, idx_ff} == (num_ff - COUNT_W'(1)));
      take     = valid_ff && rsp.ready;
      finish   = take && is_last;
      load_ok  = !valid_ff || finish;
      load     = in_valid && load_ok;
      valid_in = load ? 1'b1 : (finish ? 1'b0 : valid_ff);
      idx_in   = load ? '0 : (take ? idx_ff + SLOT_W'(1) : idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // no match leaves slot 0 zeroed from entry
   always_ff @(posedge clock) begin
      if (load) begin
         slots_ff <= in_flow.pieces;
         num_ff   <= (in_flow.count == '0) ? COUNT_W'(1) : in_flow.count;
         nm_ff    <= (in_flow.count == '0);
         tr_ff    <= !in_flow.done && (in_flow.count != '0) && (in_flow.rem != '0);
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.ram_source   = slots_ff[idx_ff].src;
   assign rsp.piece_dest   = slots_ff[idx_ff].dst;
   assign rsp.piece_length = slots_ff[idx_ff].len;
   assign rsp.no_match     = nm_ff;
   assign rsp.truncated    = tr_ff && is_last;
   assign rsp.last_piece   = is_last;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, idx_ff} < num_ff))
      else $error("piece index past piece count");

   a_no_match_single: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && nm_ff) |-> (is_last && (rsp.piece_length == '0) && !rsp.truncated))
      else $error("no-match response malformed");

endmodule
